>>> rtl/brb_pkg.sv
// Package for the byte ring buffer: field widths, operation codes and result type.
package brb_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned AMT_W  = 11;
  localparam int unsigned CNT_W  = 11;

  // Operation codes carried in the op field
  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_PEEK       = 3'd1,
    OP_DROP_FRONT = 3'd2,
    OP_DROP_BACK  = 3'd3,
    OP_CLEAR      = 3'd4
  } brb_op_e;

  // One result item
  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] read_byte;
    logic [CNT_W-1:0]  count;
  } brb_result_t;

endpackage

>>> rtl/brb_req_if.sv
// Request channel: one operation per transaction.
interface brb_req_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::OP_W-1:0]   op;
  logic [brb_pkg::BYTE_W-1:0] data_byte;
  logic [brb_pkg::AMT_W-1:0]  amount;

  modport source (output valid, output op, output data_byte, output amount, input ready);
  modport sink   (input valid, input op, input data_byte, input amount, output ready);
endinterface

>>> rtl/brb_rsp_if.sv
// Response channel: one result per transaction.
interface brb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [brb_pkg::BYTE_W-1:0] read_byte;
  logic [brb_pkg::CNT_W-1:0]  count;

  modport source (output valid, output ok, output read_byte, output count, input ready);
  modport sink   (input valid, input ok, input read_byte, input count, output ready);
endinterface

>>> rtl/brb_out_stage.sv
// Output register slice driving the response channel.
module brb_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  brb_pkg::brb_result_t in_result_i,
  brb_rsp_if.source            rsp_o
);

  logic                 valid_q, valid_d;
  brb_pkg::brb_result_t res_q;

  // Free when empty or the held result is taken this cycle
  assign in_ready_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= in_result_i;
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.ok        = res_q.ok;
  assign rsp_o.read_byte = res_q.read_byte;
  assign rsp_o.count     = res_q.count;

endmodule

>>> rtl/byte_ring_buffer_two_ended_drop.sv
// Circular byte queue with push, peek, drop at either end and clear.
//
//  channel  modport  direction  payload
//  req_i    sink     in         op[3], data_byte[8], amount[11]
//  rsp_o    source   out        ok[1], read_byte[8], count[11]
//
// One transaction per cycle sustained while rsp_o.ready stays high; each result
// is held in the memory read register and result stage, then the output register.
// Pointer and fill updates complete in the accepting cycle, so back-to-back
// operations see each other's effect; the single-port byte memory is the
// only storage touched. Reset clears pointers and count; memory is not cleared.
// Two result slots absorb a stalled response before req_i.ready drops.
module byte_ring_buffer_two_ended_drop #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brb_req_if.sink   req_i,
  brb_rsp_if.source rsp_o
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W  = ((PTR_W > brb_pkg::AMT_W) ? PTR_W : brb_pkg::AMT_W) + 1;
  localparam int unsigned CMP_W  = (FILL_W > brb_pkg::AMT_W) ? FILL_W : brb_pkg::AMT_W;

  localparam logic [EXT_W-1:0]  DEPTH_X = EXT_W'(DEPTH);
  localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_F  = FILL_W'(DEPTH);

  // Queue state
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  // Memory and read register
  logic [brb_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [brb_pkg::BYTE_W-1:0] rd_q;

  // Result stage ahead of the output register
  logic                      a_valid_q, a_valid_d;
  logic                      a_ok_q, a_peek_q;
  logic [brb_pkg::CNT_W-1:0] a_count_q;

  logic accept, b_ready, a_adv;
  logic ok, peek_ok, wr_en;

  logic [CMP_W-1:0] amt_c, fill_c, left_c, fill_next_c;
  logic [EXT_W-1:0] peek_sum, back_sum;
  logic [PTR_W-1:0] peek_addr, back_ptr, front_ptr, tail_inc;
  logic             amt_le, amt_lt, amt_nz;

  brb_pkg::brb_result_t b_result;

  assign a_adv       = a_valid_q && b_ready;
  assign req_i.ready = !a_valid_q || b_ready;
  assign accept      = req_i.valid && req_i.ready;

  // Amount checks against the fill level
  assign amt_c  = CMP_W'(req_i.amount);
  assign fill_c = CMP_W'(fill_q);
  assign amt_lt = amt_c < fill_c;
  assign amt_le = amt_c <= fill_c;
  assign amt_nz = req_i.amount != '0;
  assign left_c = fill_c - amt_c;

  // Wrapped pointers; sums stay below twice the depth where used
  assign peek_sum  = EXT_W'(head_q) + EXT_W'(req_i.amount);
  assign peek_addr = (peek_sum >= DEPTH_X) ? PTR_W'(peek_sum - DEPTH_X) : PTR_W'(peek_sum);
  assign front_ptr = peek_addr;
  assign back_sum  = EXT_W'(tail_q) + DEPTH_X - EXT_W'(req_i.amount);
  assign back_ptr  = (back_sum >= DEPTH_X) ? PTR_W'(back_sum - DEPTH_X) : PTR_W'(back_sum);
  assign tail_inc  = (tail_q == LAST_P) ? '0 : tail_q + 1'b1;

  // Operation decode and next state
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    ok      = 1'b0;
    peek_ok = 1'b0;
    wr_en   = 1'b0;
    unique case (brb_pkg::brb_op_e'(req_i.op))
      brb_pkg::OP_PUSH: begin
        if (fill_q != FULL_F) begin
          ok     = 1'b1;
          wr_en  = 1'b1;
          tail_d = tail_inc;
          fill_d = fill_q + 1'b1;
        end
      end
      brb_pkg::OP_PEEK: begin
        if (amt_lt) begin
          ok      = 1'b1;
          peek_ok = 1'b1;
        end
      end
      brb_pkg::OP_DROP_FRONT: begin
        if (amt_nz && amt_le) begin
          ok     = 1'b1;
          head_d = front_ptr;
          fill_d = FILL_W'(left_c);
        end
      end
      brb_pkg::OP_DROP_BACK: begin
        if (amt_nz && amt_le) begin
          ok     = 1'b1;
          tail_d = back_ptr;
          fill_d = FILL_W'(left_c);
        end
      end
      brb_pkg::OP_CLEAR: begin
        ok     = 1'b1;
        head_d = '0;
        tail_d = '0;
        fill_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign fill_next_c = CMP_W'(fill_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (accept) begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // Byte memory: write at tail on push, registered read at head plus offset
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem_q[tail_q] <= req_i.data_byte;
    end
    if (accept && peek_ok) begin
      rd_q <= mem_q[peek_addr];
    end
  end

  // Result stage control
  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ok_q    <= ok;
      a_peek_q  <= peek_ok;
      a_count_q <= fill_next_c[brb_pkg::CNT_W-1:0];
    end
  end

  assign b_result.ok        = a_ok_q;
  assign b_result.read_byte = a_peek_q ? rd_q : '0;
  assign b_result.count     = a_count_q;

  brb_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid_q),
    .in_ready_o  (b_ready),
    .in_result_i (b_result),
    .rsp_o       (rsp_o)
  );

endmodule

>>> bench/brb_result_checker.sv
// Result checker for the byte ring buffer: predicts each result and compares it.
`timescale 1ns / 100ps

module brb_result_checker #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brb_req_if          req_i,
  brb_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned OP_W   = brb_pkg::OP_W;
  localparam int unsigned BYTE_W = brb_pkg::BYTE_W;
  localparam int unsigned AMT_W  = brb_pkg::AMT_W;
  localparam int unsigned CNT_W  = brb_pkg::CNT_W;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  // Shadow of the ring: byte store, pointers and fill level
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  head_q;
  logic [PTR_W-1:0]  tail_q;
  logic [FILL_W-1:0] fill_q;

  brb_pkg::brb_result_t expected_q [$];
  int unsigned fails;
  int unsigned results;

  // Apply one operation to the shadow ring and return the result it gives
  function automatic brb_pkg::brb_result_t apply_op(input logic [OP_W-1:0]   op,
                                                    input logic [BYTE_W-1:0] data_v,
                                                    input logic [AMT_W-1:0]  amt);
    brb_pkg::brb_result_t res;
    res = '0;
    case (op)
      brb_pkg::OP_PUSH: begin
        if (fill_q < FILL_W'(DEPTH)) begin
          ring_mem[tail_q] = data_v;
          tail_q = PTR_W'((tail_q + 1) % DEPTH);
          fill_q = fill_q + 1'b1;
          res.ok = 1'b1;
        end
      end
      brb_pkg::OP_PEEK: begin
        if (amt < fill_q) begin
          res.read_byte = ring_mem[PTR_W'((head_q + amt) % DEPTH)];
          res.ok = 1'b1;
        end
      end
      brb_pkg::OP_DROP_FRONT: begin
        if (amt != '0 && amt <= fill_q) begin
          head_q = PTR_W'((head_q + amt) % DEPTH);
          fill_q = fill_q - FILL_W'(amt);
          res.ok = 1'b1;
        end
      end
      brb_pkg::OP_DROP_BACK: begin
        if (amt != '0 && amt <= fill_q) begin
          tail_q = PTR_W'((tail_q + DEPTH - amt) % DEPTH);
          fill_q = fill_q - FILL_W'(amt);
          res.ok = 1'b1;
        end
      end
      brb_pkg::OP_CLEAR: begin
        head_q = '0;
        tail_q = '0;
        fill_q = '0;
        res.ok = 1'b1;
      end
      default: begin
        // unused codes leave the ring alone
      end
    endcase
    res.count = CNT_W'(fill_q);
    return res;
  endfunction

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    fails++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Compare results first: a request taken at this edge cannot answer at it
  always @(posedge clk_i or negedge rst_ni) begin
    brb_pkg::brb_result_t want;
    if (!rst_ni) begin
      head_q  = '0;
      tail_q  = '0;
      fill_q  = '0;
      fails   = 0;
      results = 0;
      expected_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        results++;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual ok %0d byte %0d count %0d",
                   $time, rsp_i.ok, rsp_i.read_byte, rsp_i.count);
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.ok !== want.ok)
            note_mismatch("ok", 32'(want.ok), 32'(rsp_i.ok));
          if (rsp_i.read_byte !== want.read_byte)
            note_mismatch("read_byte", 32'(want.read_byte), 32'(rsp_i.read_byte));
          if (rsp_i.count !== want.count)
            note_mismatch("count", 32'(want.count), 32'(rsp_i.count));
        end
      end
      if (req_i.valid && req_i.ready)
        expected_q.push_back(apply_op(req_i.op, req_i.data_byte, req_i.amount));
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    checked_o    <= results;
  end

endmodule

>>> bench/tb_byte_ring_buffer_two_ended_drop.sv
// Testbench top for the byte ring buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_byte_ring_buffer_two_ended_drop;

  localparam int unsigned     OP_W            = brb_pkg::OP_W;
  localparam int unsigned     BYTE_W          = brb_pkg::BYTE_W;
  localparam int unsigned     AMT_W           = brb_pkg::AMT_W;
  localparam int unsigned     DEPTH           = 1024;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam int unsigned     GAP_PCT         = 34;
  localparam int unsigned     CYCLE_LIMIT     = 200000;
  localparam int unsigned     SETTLE_CYCLES   = 20;
  localparam int unsigned     FILL_PUSHES     = 1050;
  localparam int unsigned     QUIET_STRETCH   = 300;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        sink_ready = 1'b0;
  bit          sender_gaps = 1'b1;
  bit          sink_gaps   = 1'b1;
  int unsigned sent_ops    = 0;
  int unsigned cycles      = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  brb_req_if req ();
  brb_rsp_if rsp ();

  assign rsp.ready = sink_ready;

  byte_ring_buffer_two_ended_drop #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  brb_result_checker #(
    .DEPTH(DEPTH)
  ) u_result_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #10 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(posedge clk_i) begin
    sink_ready <= !sink_gaps || ($urandom_range(0, 99) >= GAP_PCT);
  end

  // Watchdog
  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAIL byte_ring_buffer_two_ended_drop");
    $finish;
  end

  // One transaction on the request channel, with optional idle cycles first
  task automatic issue(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data_v,
                       input logic [AMT_W-1:0] amt);
    while (sender_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.data_byte <= data_v;
    req.amount    <= amt;
    do @(posedge clk_i); while (!req.ready);
    sent_ops++;
  endtask

  // Mostly short offsets so that peeks and drops land inside the held bytes
  function automatic logic [AMT_W-1:0] pick_amount(input int unsigned near_max);
    if ($urandom_range(0, 99) < 75)
      return AMT_W'($urandom_range(0, near_max));
    return AMT_W'($urandom_range(0, DEPTH));
  endfunction

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random mix, biased towards push so the ring keeps some content
  task automatic mixed_ops(input int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        issue(brb_pkg::OP_PUSH, BYTE_W'($urandom), AMT_W'($urandom_range(0, DEPTH)));
      else if (r < 70)
        issue(brb_pkg::OP_PEEK, BYTE_W'($urandom), pick_amount(40));
      else if (r < 80)
        issue(brb_pkg::OP_DROP_FRONT, BYTE_W'($urandom), pick_amount(6));
      else if (r < 90)
        issue(brb_pkg::OP_DROP_BACK, BYTE_W'($urandom), pick_amount(6));
      else if (r < 91)
        issue(brb_pkg::OP_CLEAR, BYTE_W'($urandom), AMT_W'($urandom_range(0, DEPTH)));
      else if (r < 93)
        issue(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), BYTE_W'($urandom),
              AMT_W'($urandom_range(0, DEPTH)));
      else
        issue(brb_pkg::OP_PUSH, BYTE_W'($urandom), AMT_W'($urandom_range(0, DEPTH)));
    end
  endtask

  initial begin
    int unsigned pushes;
    int unsigned items;
    req.valid     <= 1'b0;
    req.op        <= brb_pkg::OP_PUSH;
    req.data_byte <= '0;
    req.amount    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty refusals, boundaries of peek and drop, clear, unused codes
    issue(brb_pkg::OP_PEEK,       8'h00, 11'd0);
    issue(brb_pkg::OP_DROP_FRONT, 8'h00, 11'd1);
    issue(brb_pkg::OP_DROP_BACK,  8'h00, 11'd1);
    issue(brb_pkg::OP_PUSH,       8'h00, 11'd0);
    issue(brb_pkg::OP_PUSH,       8'hFF, 11'd0);
    issue(brb_pkg::OP_PUSH,       8'hA5, AMT_W'(DEPTH));
    issue(brb_pkg::OP_PEEK,       8'h00, 11'd0);
    issue(brb_pkg::OP_PEEK,       8'h00, 11'd2);
    issue(brb_pkg::OP_PEEK,       8'h00, 11'd3);
    issue(brb_pkg::OP_PEEK,       8'h00, AMT_W'(DEPTH));
    issue(brb_pkg::OP_DROP_FRONT, 8'h00, 11'd0);
    issue(brb_pkg::OP_DROP_BACK,  8'h00, 11'd0);
    issue(brb_pkg::OP_DROP_FRONT, 8'h00, 11'd4);
    issue(brb_pkg::OP_DROP_BACK,  8'h00, 11'd1);
    issue(brb_pkg::OP_DROP_FRONT, 8'h00, 11'd1);
    issue(brb_pkg::OP_PEEK,       8'h00, 11'd0);
    issue(brb_pkg::OP_DROP_BACK,  8'h00, 11'd1);
    issue(brb_pkg::OP_PUSH,       8'h3C, 11'd0);
    issue(brb_pkg::OP_CLEAR,      8'h00, 11'd0);
    issue(brb_pkg::OP_PEEK,       8'h00, 11'd0);
    for (int unsigned c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
      issue(OP_W'(c), 8'hFF, AMT_W'(DEPTH));
    issue(brb_pkg::OP_PUSH,       8'h81, 11'd0);
    issue(brb_pkg::OP_DROP_FRONT, 8'h00, 11'd1);

    mixed_ops(65);

    // Fill past full, so the pointers wrap and late pushes are refused;
    // the first stretch runs with no idling on either side
    sender_gaps = 1'b0;
    sink_gaps   = 1'b0;
    pushes      = 0;
    items       = 0;
    while (pushes < FILL_PUSHES) begin
      if (items == QUIET_STRETCH) begin
        sender_gaps = 1'b1;
        sink_gaps   = 1'b1;
      end
      if ($urandom_range(0, 99) < 8) begin
        issue(brb_pkg::OP_PEEK, BYTE_W'($urandom), AMT_W'($urandom_range(0, DEPTH - 1)));
      end else begin
        issue(brb_pkg::OP_PUSH, BYTE_W'($urandom), AMT_W'($urandom_range(0, DEPTH)));
        pushes++;
      end
      items++;
    end

    // Hold off until every result is in, then work on the full ring
    wait_drained();
    issue(brb_pkg::OP_PEEK,       8'h00, AMT_W'(DEPTH - 1));
    issue(brb_pkg::OP_PEEK,       8'h00, AMT_W'(DEPTH));
    issue(brb_pkg::OP_PUSH,       8'h55, 11'd0);
    issue(brb_pkg::OP_DROP_BACK,  8'h00, 11'd1);
    issue(brb_pkg::OP_PUSH,       8'hAA, 11'd0);
    issue(brb_pkg::OP_PEEK,       8'h00, AMT_W'(DEPTH - 1));
    issue(brb_pkg::OP_DROP_FRONT, 8'h00, AMT_W'(DEPTH));
    issue(brb_pkg::OP_PEEK,       8'h00, 11'd0);

    mixed_ops(65);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d operations: directed edges, random mix, a fill past full with wrap,",
             sent_ops);
    $display("and work on the full ring; %0d results compared, %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("PASS byte_ring_buffer_two_ended_drop");
    else
      $display("FAIL byte_ring_buffer_two_ended_drop");
    $finish;
  end

endmodule
